### design/twl_pkg.sv
// Package for the traffic and walk light controller.
// Holds the state encoding, the lamp and next-state tables and the register map.
// Used by twl_cfg, twl_core and traffic_walk_light_fsm; depends on nothing.
package twl_pkg;

    // Field widths
    localparam int SENS_W  = 3;
    localparam int TLAMP_W = 6;
    localparam int WLAMP_W = 3;
    localparam int IDX_W   = 4;
    localparam int DWELL_W = 8;
    localparam int NSTATES = 13;

    // Register map and reset values
    localparam int                 PADDR_W        = 3;
    localparam logic               REG_LONG_DWELL  = 1'b0;
    localparam logic               REG_SHORT_DWELL = 1'b1;
    localparam logic [DWELL_W-1:0] LONG_DWELL_RST  = 8'd100;
    localparam logic [DWELL_W-1:0] SHORT_DWELL_RST = 8'd25;

    // Lamp codes
    localparam logic [TLAMP_W-1:0] TL_ALL_RED = 6'h24;
    localparam logic [TLAMP_W-1:0] TL_S_GRN   = 6'h0C;
    localparam logic [TLAMP_W-1:0] TL_S_YEL   = 6'h14;
    localparam logic [TLAMP_W-1:0] TL_W_GRN   = 6'h21;
    localparam logic [TLAMP_W-1:0] TL_W_YEL   = 6'h22;
    localparam logic [WLAMP_W-1:0] WL_OFF     = 3'd0;
    localparam logic [WLAMP_W-1:0] WL_DONT    = 3'd1;
    localparam logic [WLAMP_W-1:0] WL_WALK    = 3'd7;

    // State numbers as they appear on the output
    localparam logic [IDX_W-1:0] I_ALLRED = 4'd0;
    localparam logic [IDX_W-1:0] I_WALK   = 4'd1;
    localparam logic [IDX_W-1:0] I_WARN1  = 4'd2;
    localparam logic [IDX_W-1:0] I_OFF1   = 4'd3;
    localparam logic [IDX_W-1:0] I_WARN2  = 4'd4;
    localparam logic [IDX_W-1:0] I_OFF2   = 4'd5;
    localparam logic [IDX_W-1:0] I_WARN3  = 4'd6;
    localparam logic [IDX_W-1:0] I_SGRN   = 4'd7;
    localparam logic [IDX_W-1:0] I_SYEL   = 4'd8;
    localparam logic [IDX_W-1:0] I_SRED   = 4'd9;
    localparam logic [IDX_W-1:0] I_WGRN   = 4'd10;
    localparam logic [IDX_W-1:0] I_WYEL   = 4'd11;
    localparam logic [IDX_W-1:0] I_WRED   = 4'd12;

    // One-hot state encoding
    typedef enum logic [NSTATES-1:0] {
        S_ALLRED = 13'b0000000000001,
        S_WALK   = 13'b0000000000010,
        S_WARN1  = 13'b0000000000100,
        S_OFF1   = 13'b0000000001000,
        S_WARN2  = 13'b0000000010000,
        S_OFF2   = 13'b0000000100000,
        S_WARN3  = 13'b0000001000000,
        S_SGRN   = 13'b0000010000000,
        S_SYEL   = 13'b0000100000000,
        S_SRED   = 13'b0001000000000,
        S_WGRN   = 13'b0010000000000,
        S_WYEL   = 13'b0100000000000,
        S_WRED   = 13'b1000000000000
    } t_state;

    // Dwell settings as seen by the controller core
    typedef struct packed {
        logic [DWELL_W-1:0] long_dwell;
        logic [DWELL_W-1:0] short_dwell;
    } t_dwell_cfg;

    // Next-state table: row is the current state, column the sensor value
    localparam logic [IDX_W-1:0] SUCC [NSTATES][8] = '{
        '{I_ALLRED, I_WGRN,  I_SGRN,  I_SGRN,  I_WALK,  I_WALK,  I_WALK,  I_WALK },
        '{I_WARN1,  I_WARN1, I_WARN1, I_WARN1, I_WALK,  I_WARN1, I_WARN1, I_WARN1},
        '{I_OFF1,   I_OFF1,  I_OFF1,  I_OFF1,  I_OFF1,  I_OFF1,  I_OFF1,  I_OFF1 },
        '{I_WARN2,  I_WARN2, I_WARN2, I_WARN2, I_WARN2, I_WARN2, I_WARN2, I_WARN2},
        '{I_OFF2,   I_OFF2,  I_OFF2,  I_OFF2,  I_OFF2,  I_OFF2,  I_OFF2,  I_OFF2 },
        '{I_WARN3,  I_WARN3, I_WARN3, I_WARN3, I_WARN3, I_WARN3, I_WARN3, I_WARN3},
        '{I_ALLRED, I_WGRN,  I_SGRN,  I_SGRN,  I_WALK,  I_WGRN,  I_SGRN,  I_SGRN },
        '{I_SYEL,   I_SYEL,  I_SGRN,  I_SYEL,  I_SYEL,  I_SYEL,  I_SYEL,  I_SYEL },
        '{I_SRED,   I_SRED,  I_SRED,  I_SRED,  I_SRED,  I_SRED,  I_SRED,  I_SRED },
        '{I_ALLRED, I_WGRN,  I_SGRN,  I_WGRN,  I_WALK,  I_WGRN,  I_WALK,  I_WGRN },
        '{I_WYEL,   I_WGRN,  I_WYEL,  I_WYEL,  I_WYEL,  I_WYEL,  I_WYEL,  I_WYEL },
        '{I_WRED,   I_WRED,  I_WRED,  I_WRED,  I_WRED,  I_WRED,  I_WRED,  I_WRED },
        '{I_ALLRED, I_WGRN,  I_SGRN,  I_SGRN,  I_WALK,  I_WALK,  I_WALK,  I_WALK }
    };

    // State number of a one-hot state
    function automatic logic [IDX_W-1:0] state_to_idx(input t_state s);
        logic [IDX_W-1:0] r;
        unique case (s)
            S_ALLRED: r = I_ALLRED;
            S_WALK:   r = I_WALK;
            S_WARN1:  r = I_WARN1;
            S_OFF1:   r = I_OFF1;
            S_WARN2:  r = I_WARN2;
            S_OFF2:   r = I_OFF2;
            S_WARN3:  r = I_WARN3;
            S_SGRN:   r = I_SGRN;
            S_SYEL:   r = I_SYEL;
            S_SRED:   r = I_SRED;
            S_WGRN:   r = I_WGRN;
            S_WYEL:   r = I_WYEL;
            S_WRED:   r = I_WRED;
            default:  r = I_ALLRED;
        endcase
        return r;
    endfunction

    // One-hot state of a state number
    function automatic t_state idx_to_state(input logic [IDX_W-1:0] i);
        t_state r;
        unique case (i)
            I_ALLRED: r = S_ALLRED;
            I_WALK:   r = S_WALK;
            I_WARN1:  r = S_WARN1;
            I_OFF1:   r = S_OFF1;
            I_WARN2:  r = S_WARN2;
            I_OFF2:   r = S_OFF2;
            I_WARN3:  r = S_WARN3;
            I_SGRN:   r = S_SGRN;
            I_SYEL:   r = S_SYEL;
            I_SRED:   r = S_SRED;
            I_WGRN:   r = S_WGRN;
            I_WYEL:   r = S_WYEL;
            I_WRED:   r = S_WRED;
            default:  r = S_ALLRED;
        endcase
        return r;
    endfunction

    // Traffic lamps shown in a state
    function automatic logic [TLAMP_W-1:0] traffic_of(input t_state s);
        logic [TLAMP_W-1:0] r;
        unique case (s)
            S_SGRN:  r = TL_S_GRN;
            S_SYEL:  r = TL_S_YEL;
            S_WGRN:  r = TL_W_GRN;
            S_WYEL:  r = TL_W_YEL;
            default: r = TL_ALL_RED;
        endcase
        return r;
    endfunction

    // Walk lamps shown in a state
    function automatic logic [WLAMP_W-1:0] walk_of(input t_state s);
        logic [WLAMP_W-1:0] r;
        unique case (s)
            S_WALK:         r = WL_WALK;
            S_OFF1, S_OFF2: r = WL_OFF;
            default:        r = WL_DONT;
        endcase
        return r;
    endfunction

    // The four middle blink states use the short dwell
    function automatic logic is_short(input t_state s);
        return (s == S_WARN1) || (s == S_OFF1) || (s == S_WARN2) || (s == S_OFF2);
    endfunction

endpackage

### design/twl_cfg.sv
// Configuration register file of the traffic and walk light controller.
// Holds the long and short dwell registers behind an APB-style port.
// Depends on twl_pkg.
module twl_cfg
    import twl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output t_dwell_cfg         o_cfg
);

    logic [DWELL_W-1:0] r_long_dwell;
    logic [DWELL_W-1:0] r_short_dwell;
    logic               wr_en;
    logic               reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2];

    // Register writes; addresses beyond the list alias onto the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_dwell  <= LONG_DWELL_RST;
            r_short_dwell <= SHORT_DWELL_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_LONG_DWELL:  r_long_dwell  <= pwdata[DWELL_W-1:0];
                REG_SHORT_DWELL: r_short_dwell <= pwdata[DWELL_W-1:0];
                default: ;
            endcase
        end
    end

    // Read data is the selected register, zero-extended.
    always_comb begin
        unique case (reg_sel)
            REG_LONG_DWELL:  prdata = {{(32-DWELL_W){1'b0}}, r_long_dwell};
            REG_SHORT_DWELL: prdata = {{(32-DWELL_W){1'b0}}, r_short_dwell};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg.long_dwell  = r_long_dwell;
    assign o_cfg.short_dwell = r_short_dwell;

`ifndef SYNTHESIS
    // A completed write lands in the register that the address selects.
    a_wr_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_sel == REG_LONG_DWELL) |=> r_long_dwell == $past(pwdata[DWELL_W-1:0]))
        else $error("long dwell write lost");
    a_wr_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && reg_sel == REG_SHORT_DWELL) |=> r_short_dwell == $past(pwdata[DWELL_W-1:0]))
        else $error("short dwell write lost");
    // Without a write both registers hold.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !wr_en |=> $stable(r_long_dwell) && $stable(r_short_dwell))
        else $error("dwell register changed without a write");
`endif

endmodule

### design/twl_core.sv
// State and dwell counter of the traffic and walk light controller.
// Presents the current state's lamps and advances once per tick.
// Depends on twl_pkg.
module twl_core
    import twl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [SENS_W-1:0]  i_sensors,
    input  t_dwell_cfg         i_cfg,
    output logic [TLAMP_W-1:0] o_traffic_lamps,
    output logic [WLAMP_W-1:0] o_walk_lamps,
    output logic [IDX_W-1:0]   o_state_index
);

    t_state             r_state;
    t_state             n_state;
    logic [DWELL_W-1:0] r_ticks;
    logic [DWELL_W-1:0] n_ticks;
    logic [IDX_W-1:0]   cur_idx;
    logic               dwell_done;

    assign cur_idx    = state_to_idx(r_state);
    assign dwell_done = (r_ticks <= DWELL_W'(1));

    // Lamps of the state held during this tick.
    assign o_traffic_lamps = traffic_of(r_state);
    assign o_walk_lamps    = walk_of(r_state);
    assign o_state_index   = cur_idx;

    // Next state from the table at dwell end, else count down.
    always_comb begin
        n_state = r_state;
        n_ticks = r_ticks - DWELL_W'(1);
        if (dwell_done) begin
            n_state = idx_to_state(SUCC[cur_idx][i_sensors]);
            n_ticks = is_short(n_state) ? i_cfg.short_dwell : i_cfg.long_dwell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ALLRED;
            r_ticks <= LONG_DWELL_RST;
        end else if (i_step) begin
            r_state <= n_state;
            r_ticks <= n_ticks;
        end
    end

`ifndef SYNTHESIS
    // While the dwell runs the state holds and the count drops by one.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !dwell_done) |=> $stable(r_state) && r_ticks == $past(r_ticks) - 8'd1)
        else $error("dwell countdown broken");
    // A blink state is always entered with the short dwell loaded.
    a_short_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && dwell_done && is_short(n_state))
        |=> r_ticks == $past(i_cfg.short_dwell))
        else $error("short dwell not loaded");
    // Without a tick nothing moves.
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_state) && $stable(r_ticks))
        else $error("state moved without a tick");
`endif

endmodule

### design/traffic_walk_light_fsm.sv
// Top level of the traffic and walk light controller.
// Channel     Dir  tdata bits (low to high)                          Handshake
// s_axis      in   [2:0] sensors, [7:3] zero                        tvalid/tready
// m_axis      out  [5:0] traffic_lamps, [8:6] walk_lamps,
//                  [12:9] state_index, [15:13] zero                 tvalid/tready
// apb         in   long_dwell at 0x0, short_dwell at 0x4            psel/penable
// A tick loads the current state's lamps into the output register; the state table
// lookup and the dwell decrement feed the state registers. One tick is accepted per
// cycle but for the hold-off below. Reset (synchronous, active low) returns to the
// all-red state with a dwell of 100 and the dwell registers to 100 and 25. A tick is
// held off only while a result waits in the output register and the sink is not ready.
// Depends on twl_pkg, twl_cfg and twl_core.
module traffic_walk_light_fsm
    import twl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Ticks: [2:0] sensors
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    // Results: [5:0] traffic_lamps, [8:6] walk_lamps, [12:9] state_index
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,
    // Configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    t_dwell_cfg         cfg;
    logic               step;
    logic [TLAMP_W-1:0] traffic_lamps;
    logic [WLAMP_W-1:0] walk_lamps;
    logic [IDX_W-1:0]   state_index;
    logic               r_valid;
    logic [15:0]        r_data;

    twl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // A word enters when the output register is empty or being emptied.
    assign s_axis_tready = !r_valid || m_axis_tready;
    assign step          = s_axis_tvalid && s_axis_tready;

    twl_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_sensors       (s_axis_tdata[SENS_W-1:0]),
        .i_cfg           (cfg),
        .o_traffic_lamps (traffic_lamps),
        .o_walk_lamps    (walk_lamps),
        .o_state_index   (state_index)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_data <= {3'b000, state_index, walk_lamps, traffic_lamps};
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;

`ifndef SYNTHESIS
    // An accepted tick shows up as a result on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> m_axis_tvalid)
        else $error("accepted tick produced no result");
    // A waiting result blocks further ticks.
    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("tick accepted over a pending result");
    // The padding bits of a result stay zero.
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:13] == 3'b000)
        else $error("result padding not zero");
`endif

endmodule

### tb/sv/twl_lamp_checker.sv
// Lamp checker for the traffic and walk light controller.
// Watches the tick, result and register channels, predicts the lamps of every tick
// and compares them with the results. Depends on twl_pkg.
module twl_lamp_checker
    import twl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_s_tready,
    input  logic [7:0]         i_s_tdata,      // [2:0] sensors, [7:3] zero
    input  logic               i_m_tvalid,
    input  logic               i_m_tready,
    input  logic [15:0]        i_m_tdata,      // [5:0] traffic, [8:6] walk, [12:9] state
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_ticks,
    output int                 o_results,
    output logic [NSTATES-1:0] o_states_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // Sensor bits
    localparam logic [SENS_W-1:0] SENS_NONE = 3'b000;
    localparam logic [SENS_W-1:0] SENS_PIN2 = 3'b001;
    localparam logic [SENS_W-1:0] SENS_PIN3 = 3'b010;
    localparam logic [SENS_W-1:0] SENS_WALK = 3'b100;

    // One result word, traffic lamps in the low bits as on the bus
    typedef struct packed {
        logic [IDX_W-1:0]   idx;
        logic [WLAMP_W-1:0] walk;
        logic [TLAMP_W-1:0] traffic;
    } lamp_word_t;

    lamp_word_t         lamps_due[$];
    logic [IDX_W-1:0]   cur_idx;
    logic [DWELL_W-1:0] dwell_left;
    logic [DWELL_W-1:0] long_set;
    logic [DWELL_W-1:0] short_set;
    int                 err_count;
    int                 tick_count;
    int                 result_count;
    logic [NSTATES-1:0] seen;

    // Where a state goes when its dwell runs out.
    function automatic logic [IDX_W-1:0] next_phase(input logic [IDX_W-1:0] q,
                                                     input logic [SENS_W-1:0] s);
        logic [IDX_W-1:0] n;
        case (q)
            I_WALK:  n = (s == SENS_WALK) ? I_WALK : I_WARN1;
            I_WARN1: n = I_OFF1;
            I_OFF1:  n = I_WARN2;
            I_WARN2: n = I_OFF2;
            I_OFF2:  n = I_WARN3;
            I_SGRN:  n = (s == SENS_PIN3) ? I_SGRN : I_SYEL;
            I_SYEL:  n = I_SRED;
            I_WGRN:  n = (s == SENS_PIN2) ? I_WGRN : I_WYEL;
            I_WYEL:  n = I_WRED;
            I_WARN3: begin
                case (s)
                    SENS_NONE:                        n = I_ALLRED;
                    SENS_PIN2, SENS_WALK | SENS_PIN2: n = I_WGRN;
                    SENS_WALK:                        n = I_WALK;
                    default:                          n = I_SGRN;
                endcase
            end
            I_SRED: begin
                case (s)
                    SENS_NONE:                        n = I_ALLRED;
                    SENS_PIN3:                        n = I_SGRN;
                    SENS_WALK, SENS_WALK | SENS_PIN3: n = I_WALK;
                    default:                          n = I_WGRN;
                endcase
            end
            // All-red start and west red share one row
            default: begin
                if (s[2]) begin
                    n = I_WALK;
                end else if (s[1]) begin
                    n = I_SGRN;
                end else if (s[0]) begin
                    n = I_WGRN;
                end else begin
                    n = I_ALLRED;
                end
            end
        endcase
        return n;
    endfunction

    function automatic logic [TLAMP_W-1:0] traffic_lamps(input logic [IDX_W-1:0] q);
        case (q)
            I_SGRN:  return TL_S_GRN;
            I_SYEL:  return TL_S_YEL;
            I_WGRN:  return TL_W_GRN;
            I_WYEL:  return TL_W_YEL;
            default: return TL_ALL_RED;
        endcase
    endfunction

    function automatic logic [WLAMP_W-1:0] walk_lamps(input logic [IDX_W-1:0] q);
        case (q)
            I_WALK:         return WL_WALK;
            I_OFF1, I_OFF2: return WL_OFF;
            default:        return WL_DONT;
        endcase
    endfunction

    // The four middle blink phases run on the short dwell.
    function automatic logic blink_phase(input logic [IDX_W-1:0] q);
        return (q == I_WARN1) || (q == I_OFF1) || (q == I_WARN2) || (q == I_OFF2);
    endfunction

    // Predict on every accepted tick, compare on every accepted word.
    always @(posedge i_clk) begin : track
        lamp_word_t want;
        lamp_word_t got;
        if (!i_rst_n) begin
            cur_idx      = I_ALLRED;
            dwell_left   = LONG_DWELL_RST;
            long_set     = LONG_DWELL_RST;
            short_set    = SHORT_DWELL_RST;
            err_count    = 0;
            tick_count   = 0;
            result_count = 0;
            seen         = '0;
            lamps_due.delete();
        end else begin
            // Register writes take effect on the next dwell load
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[PADDR_W-1:2] == REG_LONG_DWELL) begin
                    long_set = i_pwdata[DWELL_W-1:0];
                end else begin
                    short_set = i_pwdata[DWELL_W-1:0];
                end
            end

            // A tick reports the current state, then counts the dwell down
            if (i_s_tvalid && i_s_tready) begin
                want.traffic = traffic_lamps(cur_idx);
                want.walk    = walk_lamps(cur_idx);
                want.idx     = cur_idx;
                lamps_due.push_back(want);
                tick_count++;
                if (dwell_left <= 1) begin
                    cur_idx    = next_phase(cur_idx, i_s_tdata[SENS_W-1:0]);
                    dwell_left = blink_phase(cur_idx) ? short_set : long_set;
                end else begin
                    dwell_left = dwell_left - 1'b1;
                end
            end

            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[TLAMP_W+WLAMP_W+IDX_W-1:0];
                if (lamps_due.size() == 0) begin
                    $error("result word 0x%h arrived with no tick waiting", i_m_tdata);
                    err_count++;
                end else begin
                    want = lamps_due.pop_front();
                    result_count++;
                    seen[want.idx] = 1'b1;
                    if (got.traffic !== want.traffic) begin
                        $error("traffic_lamps: expected 0x%h, got 0x%h",
                               want.traffic, got.traffic);
                        err_count++;
                    end
                    if (got.walk !== want.walk) begin
                        $error("walk_lamps: expected %0d, got %0d", want.walk, got.walk);
                        err_count++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("state_index: expected %0d, got %0d", want.idx, got.idx);
                        err_count++;
                    end
                end
            end
        end
        o_pending     <= lamps_due.size();
        o_errors      <= err_count;
        o_ticks       <= tick_count;
        o_results     <= result_count;
        o_states_seen <= seen;
    end

endmodule

### tb/sv/testbench.sv
// Top of the traffic and walk light controller testbench.
// Drives ticks, register writes and result back-pressure; the lamp checker judges.
// Depends on twl_pkg, traffic_walk_light_fsm and twl_lamp_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import twl_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 7;
    localparam int HOLD_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PHASES = 6;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Sensor values for the walk through every phase at a dwell of one
    localparam logic [SENS_W-1:0] WALKTHROUGH [25] = '{
        3'd7, 3'd0, 3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd0, 3'd7, 3'd3, 3'd2, 3'd7, 3'd0,
        3'd6, 3'd4, 3'd7, 3'd0, 3'd7, 3'd0, 3'd7, 3'd5, 3'd2, 3'd0, 3'd5, 3'd0
    };

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_t;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [7:0]         s_axis_tdata  = '0;
    logic               m_axis_tready = 1'b0;
    logic               psel          = 1'b0;
    logic               penable       = 1'b0;
    logic               pwrite        = 1'b0;
    logic [PADDR_W-1:0] paddr         = '0;
    logic [31:0]        pwdata        = '0;
    logic               s_axis_tready;
    logic               m_axis_tvalid;
    logic [15:0]        m_axis_tdata;
    logic [31:0]        prdata;
    logic               pready;

    int                 errors;
    int                 pending;
    int                 ticks;
    int                 results;
    logic [NSTATES-1:0] states_seen;
    int                 reg_writes = 0;
    idle_mode_t         tx_mode    = IDLE_NONE;
    idle_mode_t         rx_mode    = IDLE_NONE;
    bit                 hold_req   = 1'b0;

    traffic_walk_light_fsm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    twl_lamp_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_ticks       (ticks),
        .o_results     (results),
        .o_states_seen (states_seen)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d result words still due.", pending);
        $display("TEST FAILED");
        $finish;
    end

    // Cycles one side waits before its next word.
    function automatic int draw_gap(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:  return 0;
            IDLE_HEAVY: return $urandom_range(0, 15);
            default:    return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 15) : 0;
        endcase
    endfunction

    // Offer one tick and return at the edge that accepts it.
    task automatic send_tick(input logic [SENS_W-1:0] sens);
        int gap;
        gap = draw_gap(tx_mode);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(8 - SENS_W){1'b0}}, sens};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop offering ticks until every result word has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [DWELL_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= {{(32 - DWELL_W){1'b0}}, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic set_dwells(input logic [DWELL_W-1:0] long_val,
                              input logic [DWELL_W-1:0] short_val);
        apb_write(REG_LONG_DWELL, long_val);
        apb_write(REG_SHORT_DWELL, short_val);
    endtask

    // Result sink: random stalls, and one long hold-off on request.
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = draw_gap(rx_mode);
                if (stall > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // Tick source and verdict.
    initial begin
        int len;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset dwells: leave all-red on a walk request after 100 ticks, then leave
        // walk after another 100, which loads the short dwell of 25.
        for (int k = 1; k <= 200; k++) begin
            tx_mode = (k <= 100) ? IDLE_NONE : IDLE_LIGHT;
            rx_mode = (k <= 100) ? IDLE_NONE : IDLE_HEAVY;
            if (k == 100) begin
                send_tick(SENS_W'($urandom_range(4, 7)));
            end else if (k == 200) begin
                send_tick(SENS_W'($urandom_range(0, 3)));
            end else begin
                send_tick(SENS_W'($urandom_range(0, 7)));
            end
        end

        // Dwell of one; the running count of 25 still finishes first.
        wait_drained();
        set_dwells(8'd1, 8'd1);
        tx_mode = IDLE_HEAVY;
        rx_mode = IDLE_LIGHT;
        for (int k = 0; k < 25; k++) begin
            send_tick(SENS_W'($urandom_range(0, 7)));
        end
        foreach (WALKTHROUGH[k]) begin
            send_tick(WALKTHROUGH[k]);
        end

        // Random sensors over short dwells, including a dwell written as zero.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_drained();
            if (p == 2) begin
                set_dwells(8'd0, 8'd0);
            end else begin
                set_dwells(DWELL_W'($urandom_range(1, 6)), DWELL_W'($urandom_range(1, 4)));
            end
            tx_mode = idle_mode_t'(p % 3);
            rx_mode = idle_mode_t'((p + 1) % 3);
            len = $urandom_range(35, 45);
            for (int k = 0; k < len; k++) begin
                if (p == 3 && k == 4) begin
                    hold_req = 1'b1;
                end
                if (p == 4 && k == len / 2) begin
                    wait_drained();
                end
                send_tick(SENS_W'($urandom_range(0, 7)));
            end
        end

        // Largest dwells.
        wait_drained();
        set_dwells(8'd255, 8'd255);
        tx_mode = IDLE_LIGHT;
        rx_mode = IDLE_LIGHT;
        for (int k = 0; k < 60; k++) begin
            send_tick(SENS_W'($urandom_range(0, 7)));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Ran %0d ticks and checked %0d result words over %0d register writes.",
                 ticks, results, reg_writes);
        $display("Dwells ranged from zero to 255; states reached (bit per state): %b.",
                 states_seen);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
